// File: hw/rtl/bstt_pkg.sv
`default_nettype none
package bstt_pkg;

    localparam int unsigned PC_W      = 4;
    localparam int unsigned IN_W      = 72;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned BIN_W     = 24;
    localparam int unsigned BCD_W     = 32;
    localparam int unsigned WRITTEN_W = 4;

    localparam logic [CNT_W-1:0] DABBLE_LAST = 5'd23;
    localparam logic [2:0]       UNIT_MAX    = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;

    // program steps
    localparam logic [PC_W-1:0] ST_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] ST_SCALE    = 4'd1;
    localparam logic [PC_W-1:0] ST_BCD_INIT = 4'd2;
    localparam logic [PC_W-1:0] ST_DABBLE   = 4'd3;
    localparam logic [PC_W-1:0] ST_DIG_INIT = 4'd4;
    localparam logic [PC_W-1:0] ST_SKIP     = 4'd5;
    localparam logic [PC_W-1:0] ST_DIGIT    = 4'd6;
    localparam logic [PC_W-1:0] ST_DOT      = 4'd7;
    localparam logic [PC_W-1:0] ST_TENTH    = 4'd8;
    localparam logic [PC_W-1:0] ST_SPACE    = 4'd9;
    localparam logic [PC_W-1:0] ST_UNIT_A   = 4'd10;
    localparam logic [PC_W-1:0] ST_UNIT_B   = 4'd11;
    localparam logic [PC_W-1:0] ST_FLUSH    = 4'd12;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD,
        ACT_SCALE,
        ACT_BCD_INIT,
        ACT_DABBLE,
        ACT_DIG_INIT,
        ACT_SKIP,
        ACT_DEC,
        ACT_FLUSH
    } t_act;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_WAIT,
        COND_SCALE,
        COND_CNT_NZ,
        COND_SKIP,
        COND_NO_DOT
    } t_cond;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_DIGIT,
        SRC_DOT,
        SRC_TENTH,
        SRC_SPACE,
        SRC_UNIT_A,
        SRC_UNIT_B
    } t_src;

    typedef struct packed {
        t_act             act;
        t_src             src;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic scale;
        logic cnt_nz;
        logic skip;
        logic no_dot;
        logic stall;
    } t_flags;

    function automatic logic [7:0] unit_letter(input logic [2:0] unit);
        logic [7:0] ch;
        case (unit)
            3'd0:    ch = CH_B;
            3'd1:    ch = CH_K;
            3'd2:    ch = CH_M;
            3'd3:    ch = CH_G;
            default: ch = CH_T;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/byte_size_to_text.sv
// one program step per cycle while the output is not stalled: 1 to 5 scale steps,
// 24 shift-add steps, 9 steps for leading zeros and digits, and 7 or 8 steps for setup,
// point, tenths, space, unit and flush.
// a new request is taken only in the wait step; a stalled output holds the program in place,
// and the last character may still sit in the output register when the next is taken.
// reset: synchronous active-low i_rst_n returns the step counter to wait, empties the output.
`default_nettype none
module byte_size_to_text (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // byte_count[63:0], buffer_size[71:64]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // char_code[7:0]
    output logic             m_axis_tuser,   // char_valid[0]
    output logic             m_axis_tlast
);

    logic [bstt_pkg::PC_W-1:0] r_pc, n_pc;
    bstt_pkg::t_uword          uword;
    bstt_pkg::t_flags          flags;
    logic                      cond_true;
    logic                      accept;

    bstt_rom u_rom (
        .i_pc    (r_pc),
        .o_uword (uword)
    );

    assign s_axis_tready = (uword.act == bstt_pkg::ACT_LOAD);
    assign accept        = s_axis_tvalid && s_axis_tready;

    bstt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (uword),
        .i_load      (accept),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_flags     (flags),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    always_comb begin
        case (uword.cond)
            bstt_pkg::COND_ALWAYS:  cond_true = 1'b1;
            bstt_pkg::COND_IN_WAIT: cond_true = !s_axis_tvalid;
            bstt_pkg::COND_SCALE:   cond_true = flags.scale;
            bstt_pkg::COND_CNT_NZ:  cond_true = flags.cnt_nz;
            bstt_pkg::COND_SKIP:    cond_true = flags.skip;
            bstt_pkg::COND_NO_DOT:  cond_true = flags.no_dot;
            default:                cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (flags.stall) begin
            n_pc = r_pc;
        end else if (cond_true) begin
            n_pc = uword.target;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= bstt_pkg::ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bstt_rom.sv
`default_nettype none
module bstt_rom (
    input  wire logic [bstt_pkg::PC_W-1:0] i_pc,
    output bstt_pkg::t_uword                o_uword
);

    always_comb begin
        o_uword = '{bstt_pkg::ACT_NOP, bstt_pkg::SRC_NONE, bstt_pkg::COND_NEVER,
                    bstt_pkg::ST_WAIT};
        case (i_pc)
            bstt_pkg::ST_WAIT: begin
                o_uword = '{bstt_pkg::ACT_LOAD, bstt_pkg::SRC_NONE,
                            bstt_pkg::COND_IN_WAIT, bstt_pkg::ST_WAIT};
            end
            bstt_pkg::ST_SCALE: begin
                o_uword = '{bstt_pkg::ACT_SCALE, bstt_pkg::SRC_NONE,
                            bstt_pkg::COND_SCALE, bstt_pkg::ST_SCALE};
            end
            bstt_pkg::ST_BCD_INIT: begin
                o_uword = '{bstt_pkg::ACT_BCD_INIT, bstt_pkg::SRC_NONE,
                            bstt_pkg::COND_NEVER, bstt_pkg::ST_WAIT};
            end
            bstt_pkg::ST_DABBLE: begin
                o_uword = '{bstt_pkg::ACT_DABBLE, bstt_pkg::SRC_NONE,
                            bstt_pkg::COND_CNT_NZ, bstt_pkg::ST_DABBLE};
            end
            bstt_pkg::ST_DIG_INIT: begin
                o_uword = '{bstt_pkg::ACT_DIG_INIT, bstt_pkg::SRC_NONE,
                            bstt_pkg::COND_NEVER, bstt_pkg::ST_WAIT};
            end
            bstt_pkg::ST_SKIP: begin
                o_uword = '{bstt_pkg::ACT_SKIP, bstt_pkg::SRC_NONE,
                            bstt_pkg::COND_SKIP, bstt_pkg::ST_SKIP};
            end
            bstt_pkg::ST_DIGIT: begin
                o_uword = '{bstt_pkg::ACT_DEC, bstt_pkg::SRC_DIGIT,
                            bstt_pkg::COND_CNT_NZ, bstt_pkg::ST_DIGIT};
            end
            bstt_pkg::ST_DOT: begin
                o_uword = '{bstt_pkg::ACT_NOP, bstt_pkg::SRC_DOT,
                            bstt_pkg::COND_NO_DOT, bstt_pkg::ST_SPACE};
            end
            bstt_pkg::ST_TENTH: begin
                o_uword = '{bstt_pkg::ACT_NOP, bstt_pkg::SRC_TENTH,
                            bstt_pkg::COND_NEVER, bstt_pkg::ST_WAIT};
            end
            bstt_pkg::ST_SPACE: begin
                o_uword = '{bstt_pkg::ACT_NOP, bstt_pkg::SRC_SPACE,
                            bstt_pkg::COND_NEVER, bstt_pkg::ST_WAIT};
            end
            bstt_pkg::ST_UNIT_A: begin
                o_uword = '{bstt_pkg::ACT_NOP, bstt_pkg::SRC_UNIT_A,
                            bstt_pkg::COND_NEVER, bstt_pkg::ST_WAIT};
            end
            bstt_pkg::ST_UNIT_B: begin
                o_uword = '{bstt_pkg::ACT_NOP, bstt_pkg::SRC_UNIT_B,
                            bstt_pkg::COND_NEVER, bstt_pkg::ST_WAIT};
            end
            bstt_pkg::ST_FLUSH: begin
                o_uword = '{bstt_pkg::ACT_FLUSH, bstt_pkg::SRC_NONE,
                            bstt_pkg::COND_ALWAYS, bstt_pkg::ST_WAIT};
            end
            default: begin
                o_uword = '{bstt_pkg::ACT_NOP, bstt_pkg::SRC_NONE,
                            bstt_pkg::COND_ALWAYS, bstt_pkg::ST_WAIT};
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/bstt_datapath.sv
`default_nettype none
module bstt_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bstt_pkg::t_uword            i_uword,
    input  wire logic                        i_load,
    input  wire logic [bstt_pkg::IN_W-1:0]   i_in_data,
    input  wire logic                        i_out_ready,
    output bstt_pkg::t_flags                 o_flags,
    output logic                             o_out_valid,
    output logic [7:0]                       o_out_char,
    output logic                             o_out_user,
    output logic                             o_out_last
);

    logic [63:0]                        r_whole, n_whole;
    logic [7:0]                         r_room, n_room;
    logic [2:0]                         r_unit, n_unit;
    logic [3:0]                         r_tenths, n_tenths;
    logic [bstt_pkg::BIN_W-1:0]         r_bin, n_bin;
    logic [bstt_pkg::BCD_W-1:0]         r_bcd, n_bcd;
    logic [bstt_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [bstt_pkg::WRITTEN_W-1:0]     r_written, n_written;
    logic                               r_pend_valid, n_pend_valid;
    logic [7:0]                         r_pend_char, n_pend_char;
    logic                               r_out_valid, n_out_valid;
    logic [7:0]                         r_out_char, n_out_char;
    logic                               r_out_user, n_out_user;
    logic                               r_out_last, n_out_last;

    logic [3:0]  digit;
    logic [13:0] tenth_prod;
    logic        scale_ok;
    logic        dot_ok;
    logic        fits;
    logic        gate;
    logic        fire;
    logic        need_out;
    logic        out_free;
    logic        stall;
    logic [7:0]  ch;
    logic [bstt_pkg::BCD_W-1:0] adj;

    assign digit      = r_bcd[r_cnt[2:0]*4 +: 4];
    assign tenth_prod = {4'd0, r_whole[9:0]} * 14'd10;
    assign scale_ok   = (|r_whole[63:10]) && (r_unit < bstt_pkg::UNIT_MAX);
    assign dot_ok     = (r_unit != 3'd0)
                        && (({4'd0, r_written} + 8'd3) < r_room);
    assign fits       = ({4'd0, r_written} + 8'd1) < r_room;

    always_comb begin
        case (i_uword.src)
            bstt_pkg::SRC_DIGIT:  ch = bstt_pkg::CH_ZERO | {4'd0, digit};
            bstt_pkg::SRC_DOT:    ch = bstt_pkg::CH_DOT;
            bstt_pkg::SRC_TENTH:  ch = bstt_pkg::CH_ZERO | {4'd0, r_tenths};
            bstt_pkg::SRC_SPACE:  ch = bstt_pkg::CH_SPACE;
            bstt_pkg::SRC_UNIT_A: ch = bstt_pkg::unit_letter(r_unit);
            bstt_pkg::SRC_UNIT_B: ch = bstt_pkg::CH_B;
            default:              ch = bstt_pkg::CH_SPACE;
        endcase
        case (i_uword.src)
            bstt_pkg::SRC_NONE:   gate = 1'b0;
            bstt_pkg::SRC_DOT:    gate = dot_ok;
            bstt_pkg::SRC_UNIT_B: gate = (r_unit != 3'd0);
            default:              gate = 1'b1;
        endcase
    end

    assign fire     = gate && fits;
    assign need_out = (fire && r_pend_valid) || (i_uword.act == bstt_pkg::ACT_FLUSH);
    assign out_free = !r_out_valid || i_out_ready;
    assign stall    = need_out && !out_free;

    // add-3 correction on every bcd digit before the shift
    always_comb begin
        for (int i = 0; i < bstt_pkg::BCD_W / 4; i++) begin
            adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                       : r_bcd[i*4 +: 4];
        end
    end

    always_comb begin
        n_whole      = r_whole;
        n_room       = r_room;
        n_unit       = r_unit;
        n_tenths     = r_tenths;
        n_bin        = r_bin;
        n_bcd        = r_bcd;
        n_cnt        = r_cnt;
        n_written    = r_written;
        n_pend_valid = r_pend_valid;
        n_pend_char  = r_pend_char;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_char   = r_out_char;
        n_out_user   = r_out_user;
        n_out_last   = r_out_last;
        if (!stall) begin
            case (i_uword.act)
                bstt_pkg::ACT_LOAD: begin
                    if (i_load) begin
                        n_whole      = i_in_data[63:0];
                        n_room       = i_in_data[71:64];
                        n_unit       = 3'd0;
                        n_tenths     = 4'd0;
                        n_written    = '0;
                        n_pend_valid = 1'b0;
                    end
                end
                bstt_pkg::ACT_SCALE: begin
                    if (scale_ok) begin
                        n_tenths = tenth_prod[13:10];
                        n_whole  = {10'd0, r_whole[63:10]};
                        n_unit   = r_unit + 3'd1;
                    end
                end
                bstt_pkg::ACT_BCD_INIT: begin
                    n_bcd = '0;
                    n_bin = r_whole[bstt_pkg::BIN_W-1:0];
                    n_cnt = bstt_pkg::DABBLE_LAST;
                end
                bstt_pkg::ACT_DABBLE: begin
                    n_bcd = {adj[bstt_pkg::BCD_W-2:0], r_bin[bstt_pkg::BIN_W-1]};
                    n_bin = {r_bin[bstt_pkg::BIN_W-2:0], 1'b0};
                    n_cnt = r_cnt - 5'd1;
                end
                bstt_pkg::ACT_DIG_INIT: begin
                    n_cnt = 5'd7;
                end
                bstt_pkg::ACT_SKIP: begin
                    if (digit == 4'd0 && r_cnt != '0) begin
                        n_cnt = r_cnt - 5'd1;
                    end
                end
                bstt_pkg::ACT_DEC: begin
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - 5'd1;
                    end
                end
                bstt_pkg::ACT_FLUSH: begin
                    n_out_valid  = 1'b1;
                    n_out_char   = r_pend_valid ? r_pend_char : 8'd0;
                    n_out_user   = r_pend_valid;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
                default: begin
                end
            endcase
            // each new character pushes the one held before it
            if (fire) begin
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_pend_char;
                    n_out_user  = 1'b1;
                    n_out_last  = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_char  = ch;
                n_written    = r_written + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_whole     <= n_whole;
        r_room      <= n_room;
        r_unit      <= n_unit;
        r_tenths    <= n_tenths;
        r_bin       <= n_bin;
        r_bcd       <= n_bcd;
        r_cnt       <= n_cnt;
        r_written   <= n_written;
        r_pend_char <= n_pend_char;
        r_out_char  <= n_out_char;
        r_out_user  <= n_out_user;
        r_out_last  <= n_out_last;
    end

    assign o_flags.scale  = scale_ok;
    assign o_flags.cnt_nz = (r_cnt != '0);
    assign o_flags.skip   = (digit == 4'd0) && (r_cnt != '0);
    assign o_flags.no_dot = !dot_ok;
    assign o_flags.stall  = stall;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire
